// File: sv/carp_pkg.sv
// Shared types, codes and chord tables for the chord arpeggiator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package carp_pkg;

   // Widths
   localparam int TIME_BITS  = 32;
   localparam int NOTE_W     = 8;
   localparam int CHORD_W    = 4;
   localparam int MODE_W     = 3;
   localparam int SPACE_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int IDX_W      = 2;
   localparam int CNT_W      = 3;
   localparam int PREV_W     = NOTE_W + 1;
   localparam int ROW_W      = 4 * NOTE_W;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [NOTE_W-1:0]    note_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHORD_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARP_MODE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_FACTOR = 2'd2;

   // Opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Arp modes
   localparam logic [MODE_W-1:0] MODE_ONE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CHORD   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UP      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DOWN    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UD_INCL = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DU_INCL = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UD_EXCL = 3'd6;
   localparam logic [MODE_W-1:0] MODE_DU_EXCL = 3'd7;

   // Chord types
   localparam logic [CHORD_W-1:0] CHORD_MAJ  = 4'd0;
   localparam logic [CHORD_W-1:0] CHORD_MIN  = 4'd1;
   localparam logic [CHORD_W-1:0] CHORD_DIM  = 4'd2;
   localparam logic [CHORD_W-1:0] CHORD_MAJ7 = 4'd3;
   localparam logic [CHORD_W-1:0] CHORD_MIN7 = 4'd4;
   localparam logic [CHORD_W-1:0] CHORD_DOM7 = 4'd5;
   localparam logic [CHORD_W-1:0] CHORD_SUS2 = 4'd6;
   localparam logic [CHORD_W-1:0] CHORD_SUS4 = 4'd7;
   localparam logic [CHORD_W-1:0] CHORD_AUG  = 4'd8;

   // Marker for no previous note (top bit set)
   localparam logic [PREV_W-1:0] PREV_NONE = 9'h100;

   // Controller to datapath
   typedef struct packed {
      logic             load_base;
      logic             load_stride;
      logic             set_dir;
      logic             emit_note;
      logic             emit_done;
      logic             pass_last;
      logic             advance;
      logic             record_prev;
      logic             toggle_dir;
      logic [IDX_W-1:0] note_idx;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic              loaded;
      logic              span_hit;
      logic [CNT_W-1:0]  note_cnt;
      logic [MODE_W-1:0] mode;
      logic              skip;
      logic              out_free;
   } stat_type;

   // Semitone intervals, slot 0 in the low byte; unused codes read as all zero
   function automatic note_type chord_interval(input logic [CHORD_W-1:0] ct,
                                               input logic [IDX_W-1:0] idx);
      logic [ROW_W-1:0] row;
      case (ct)
         CHORD_MAJ:  row = {8'd0,  8'd7, 8'd4, 8'd0};
         CHORD_MIN:  row = {8'd0,  8'd7, 8'd3, 8'd0};
         CHORD_DIM:  row = {8'd0,  8'd6, 8'd3, 8'd0};
         CHORD_MAJ7: row = {8'd11, 8'd7, 8'd4, 8'd0};
         CHORD_MIN7: row = {8'd10, 8'd7, 8'd3, 8'd0};
         CHORD_DOM7: row = {8'd10, 8'd7, 8'd4, 8'd0};
         CHORD_SUS2: row = {8'd0,  8'd7, 8'd2, 8'd0};
         CHORD_SUS4: row = {8'd0,  8'd7, 8'd5, 8'd0};
         CHORD_AUG:  row = {8'd0,  8'd8, 8'd4, 8'd0};
         default:    row = '0;
      endcase
      return row[{idx, 3'b000} +: NOTE_W];
   endfunction

   // Number of notes in a chord; unused codes give an empty chord
   function automatic logic [CNT_W-1:0] chord_count(input logic [CHORD_W-1:0] ct);
      case (ct)
         CHORD_MAJ7, CHORD_MIN7, CHORD_DOM7:                    return 3'd4;
         CHORD_MAJ, CHORD_MIN, CHORD_DIM, CHORD_SUS2,
         CHORD_SUS4, CHORD_AUG:                                 return 3'd3;
         default:                                               return 3'd0;
      endcase
   endfunction

endpackage

// File: sv/carp_req_if.sv
// Request channel of the chord arpeggiator: valid, ready and one input item.
// Depends on carp_pkg.
interface carp_req_if import carp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   note_type         base_note;
   logic [7:0]       base_velocity;
   time_type         on_time_in;
   time_type         off_time_in;
   time_type         region_span;

   modport source (output valid, opcode, base_note, base_velocity, on_time_in,
                   off_time_in, region_span, input ready);
   modport sink   (input valid, opcode, base_note, base_velocity, on_time_in,
                   off_time_in, region_span, output ready);
endinterface

// File: sv/carp_rsp_if.sv
// Response channel of the chord arpeggiator: valid, ready and one result item.
// Depends on carp_pkg.
interface carp_rsp_if import carp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             note_valid;
   note_type         note_out;
   logic [7:0]       velocity_out;
   time_type         on_time_out;
   time_type         off_time_out;
   logic             pass_last;
   logic             done_res;

   modport source (output valid, note_valid, note_out, velocity_out, on_time_out,
                   off_time_out, pass_last, done_res, input ready);
   modport sink   (input valid, note_valid, note_out, velocity_out, on_time_out,
                   off_time_out, pass_last, done_res, output ready);
endinterface

// File: sv/carp_ctrl.sv
// Sequencer of the chord arpeggiator: walks load and step items through the datapath.
// Depends on carp_pkg; drives carp_dpath by command, reads its status.
module carp_ctrl import carp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_opcode,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pass_cnt;
   logic             last_note;
   logic             alt_mode;
   logic             excl_mode;

   // Notes in this pass: mode one always plays the root alone
   assign pass_cnt  = (stat.mode == MODE_ONE) ? CNT_W'(1) : stat.note_cnt;
   assign last_note = ({1'b0, idx_ff} == CNT_W'(pass_cnt - CNT_W'(1)));
   assign alt_mode  = (stat.mode >= MODE_UD_INCL);
   assign excl_mode = (stat.mode >= MODE_UD_EXCL);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.note_idx = idx_ff;
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.load_base = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_stride = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_CHECK: begin
            if (!stat.loaded || stat.span_hit) begin
               // hold until the output register frees up, then report done
               if (stat.out_free) begin
                  cmd.emit_done = 1'b1;
                  cmd.pass_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.set_dir = 1'b1;
               idx_in      = '0;
               if (pass_cnt == '0) begin
                  // empty chord: no beats, but keep the timing bookkeeping
                  cmd.advance    = (stat.mode == MODE_CHORD);
                  cmd.toggle_dir = alt_mode;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (stat.skip) begin
               // drop a repeat of the last note played
               idx_in = idx_ff + IDX_W'(1);
               if (last_note) begin
                  cmd.toggle_dir = alt_mode;
                  state_in       = ST_IDLE;
               end
            end else if (stat.out_free) begin
               cmd.emit_note   = 1'b1;
               cmd.pass_last   = last_note;
               cmd.record_prev = excl_mode;
               cmd.advance     = (stat.mode >= MODE_UP) || last_note;
               idx_in          = idx_ff + IDX_W'(1);
               if (last_note) begin
                  cmd.toggle_dir = alt_mode;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// File: sv/carp_dpath.sv
// Datapath of the chord arpeggiator: configuration, base event, timing and output register.
// Depends on carp_pkg; commanded by carp_ctrl.
module carp_dpath import carp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request payload
   input  note_type              req_base_note,
   input  logic [7:0]            req_base_velocity,
   input  time_type              req_on_time_in,
   input  time_type              req_off_time_in,
   input  time_type              req_region_span,
   // control
   input  cmd_type               cmd,
   output stat_type              stat,
   // response
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_note_valid,
   output note_type              rsp_note_out,
   output logic [7:0]            rsp_velocity_out,
   output time_type              rsp_on_time_out,
   output time_type              rsp_off_time_out,
   output logic                  rsp_pass_last,
   output logic                  rsp_done_res
);

   logic [CHORD_W-1:0]        chord_type_ff;
   logic [MODE_W-1:0]         arp_mode_ff;
   logic [SPACE_W-1:0]        space_ff;
   note_type                  root_ff;
   logic [7:0]                vel_ff;
   time_type                  start_ff;
   time_type                  len_ff;
   time_type                  stride_ff;
   time_type                  span_ff;
   logic [PREV_W-1:0]         prev_ff;
   logic                      desc_next_ff;
   logic                      loaded_ff;
   logic                      dir_ff;
   logic                      dir_in;
   logic [TIME_BITS+SPACE_W:0] stride_prod;
   time_type                  end_time;
   logic                      span_hit;
   logic [CNT_W-1:0]          note_cnt;
   logic [CNT_W-1:0]          rev_ord;
   logic [IDX_W-1:0]          ord;
   note_type                  note_sel;
   logic                      out_free;
   logic                      rsp_valid_ff;
   logic                      rsp_note_valid_ff;
   note_type                  rsp_note_ff;
   logic [7:0]                rsp_vel_ff;
   time_type                  rsp_on_ff;
   time_type                  rsp_off_ff;
   logic                      rsp_last_ff;
   logic                      rsp_done_ff;

   // Span check and end time of the current event
   assign end_time = start_ff + len_ff;
   assign span_hit = (end_time >= span_ff);

   // Stride: note length times one plus the gap factor
   assign stride_prod = len_ff * ({1'b0, space_ff} + (SPACE_W+1)'(1));

   // Pick the chord slot, reversed on a descending pass
   assign note_cnt = chord_count(chord_type_ff);
   assign rev_ord  = CNT_W'(note_cnt - CNT_W'(1) - {1'b0, cmd.note_idx});
   assign ord      = dir_ff ? rev_ord[IDX_W-1:0] : cmd.note_idx;
   assign note_sel = root_ff + chord_interval(chord_type_ff, ord);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Direction of the pass about to start
   always_comb begin
      case (arp_mode_ff)
         MODE_DOWN:                  dir_in = 1'b1;
         MODE_UD_INCL, MODE_UD_EXCL: dir_in = desc_next_ff;
         MODE_DU_INCL, MODE_DU_EXCL: dir_in = !desc_next_ff;
         default:                    dir_in = 1'b0;
      endcase
   end

   always_comb begin
      stat          = '0;
      stat.loaded   = loaded_ff;
      stat.span_hit = span_hit;
      stat.note_cnt = note_cnt;
      stat.mode     = arp_mode_ff;
      stat.skip     = (arp_mode_ff >= MODE_UD_EXCL) && ({1'b0, note_sel} == prev_ff);
      stat.out_free = out_free;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chord_type_ff <= '0;
         arp_mode_ff   <= '0;
         space_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHORD_TYPE:   chord_type_ff <= csr_wdata;
            CSR_ARP_MODE:     arp_mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_SPACE_FACTOR: space_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Base event and pass state
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         vel_ff       <= '0;
         start_ff     <= '0;
         len_ff       <= '0;
         stride_ff    <= '0;
         span_ff      <= '0;
         prev_ff      <= PREV_NONE;
         desc_next_ff <= 1'b0;
         loaded_ff    <= 1'b0;
         dir_ff       <= 1'b0;
      end else begin
         if (cmd.load_base) begin
            root_ff      <= req_base_note;
            vel_ff       <= req_base_velocity;
            start_ff     <= req_on_time_in;
            len_ff       <= req_off_time_in - req_on_time_in;
            span_ff      <= req_region_span;
            prev_ff      <= PREV_NONE;
            desc_next_ff <= 1'b0;
            loaded_ff    <= 1'b1;
         end
         if (cmd.load_stride) begin
            stride_ff <= stride_prod[TIME_BITS-1:0];
         end
         if (cmd.set_dir) begin
            dir_ff <= dir_in;
         end
         if (cmd.advance) begin
            start_ff <= start_ff + stride_ff;
         end
         if (cmd.record_prev) begin
            prev_ff <= {1'b0, note_sel};
         end
         if (cmd.toggle_dir) begin
            desc_next_ff <= !desc_next_ff;
         end
      end
   end

   // Output register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_note || cmd.emit_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register: payload
   always_ff @(posedge clock) begin
      if (cmd.emit_note) begin
         rsp_note_valid_ff <= 1'b1;
         rsp_note_ff       <= note_sel;
         rsp_vel_ff        <= vel_ff;
         rsp_on_ff         <= start_ff;
         rsp_off_ff        <= end_time;
         rsp_last_ff       <= cmd.pass_last;
         rsp_done_ff       <= 1'b0;
      end else if (cmd.emit_done) begin
         rsp_note_valid_ff <= 1'b0;
         rsp_note_ff       <= '0;
         rsp_vel_ff        <= '0;
         rsp_on_ff         <= '0;
         rsp_off_ff        <= '0;
         rsp_last_ff       <= 1'b1;
         rsp_done_ff       <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_note_valid   = rsp_note_valid_ff;
   assign rsp_note_out     = rsp_note_ff;
   assign rsp_velocity_out = rsp_vel_ff;
   assign rsp_on_time_out  = rsp_on_ff;
   assign rsp_off_time_out = rsp_off_ff;
   assign rsp_pass_last    = rsp_last_ff;
   assign rsp_done_res     = rsp_done_ff;

`ifndef SYNTHESIS
   // Never overwrite a beat that has not been taken
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_note || cmd.emit_done) |-> out_free)
      else $error("carp_dpath: result written over a pending beat");

   // Done is only reported with nothing loaded or the span reached
   a_done_cause: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_done |-> (!loaded_ff || span_hit))
      else $error("carp_dpath: done reported while generation still open");

   // Exclusive modes never repeat the previous note
   a_excl_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_note && (arp_mode_ff >= MODE_UD_EXCL)) |-> ({1'b0, note_sel} != prev_ff))
      else $error("carp_dpath: exclusive mode repeated the previous note");

   // Stride is taken right after the base event is latched
   a_stride_after_base: assert property (@(posedge clock) disable iff (reset)
      cmd.load_stride |-> $past(cmd.load_base))
      else $error("carp_dpath: stride update without a preceding load");
`endif

endmodule

// File: sv/chord_arpeggiator_unit.sv
// Top level of the chord arpeggiator: joins the sequencer and the datapath.
// Depends on carp_pkg, carp_req_if, carp_rsp_if, carp_ctrl and carp_dpath.
//
//   channel   direction  beat contents
//   req_chan  in         opcode, base note, velocity, on/off time, region span
//   rsp_chan  out        note flag, note, velocity, on/off time, pass last, done
//   csr_*     in         write enable, register index, write data (no read-back)
//
// A load latches the base event, then takes the stride multiply.
// A step walks the chord slots (0, 1, 3 or 4) one at a time in the sequencer,
// one beat per cycle at most while the response is not stalled.
// Synchronous active-high reset clears configuration and event state (previous note to none).
// A stalled response holds the walk; the next item is taken while the last beat waits.
module chord_arpeggiator_unit import carp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   carp_req_if.sink              req_chan,
   carp_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_chan.ready = req_ready;

   // Sequencer
   carp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath
   carp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_base_note     (req_chan.base_note),
      .req_base_velocity (req_chan.base_velocity),
      .req_on_time_in    (req_chan.on_time_in),
      .req_off_time_in   (req_chan.off_time_in),
      .req_region_span   (req_chan.region_span),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_note_valid    (rsp_chan.note_valid),
      .rsp_note_out      (rsp_chan.note_out),
      .rsp_velocity_out  (rsp_chan.velocity_out),
      .rsp_on_time_out   (rsp_chan.on_time_out),
      .rsp_off_time_out  (rsp_chan.off_time_out),
      .rsp_pass_last     (rsp_chan.pass_last),
      .rsp_done_res      (rsp_chan.done_res)
   );

endmodule
